@@ rtl/core/sbpsd_pkg.sv @@
// Shared types and constants of the spectral band peak slip detector.
package sbpsd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 57;
    localparam int START_W     = 10;
    localparam int SPACING_W   = 16;
    localparam int POWER_W     = 32;
    localparam int FREQ_W      = 25;
    localparam int IND_W       = 57;
    localparam int SAMPLE_W    = 16;
    localparam int SQUARE_W    = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FIRST     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_BIN        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIN_SPACING_HZ = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLIP_THRESHOLD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_PRODUCT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic square;
        logic update;
        logic product;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/sbpsd_ctrl.sv @@
// Sequencing state machine of the spectral band peak slip detector.
module sbpsd_ctrl
    import sbpsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.last ? ST_PRODUCT : ST_IDLE;
            end
            ST_PRODUCT: begin
                o_cmd.product = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/sbpsd_datapath.sv @@
// Datapath: band power, running peak, indicator and output register.
module sbpsd_datapath
    import sbpsd_pkg::*;
#(
    parameter int FFT_SIZE = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_bin_real,
    input  logic signed [SAMPLE_W-1:0] i_bin_imag,
    input  logic                       i_last_bin,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_slip_detected,
    output logic [IND_W-1:0]           o_slip_metric,
    output logic [POWER_W-1:0]         o_peak_power,
    output logic [FREQ_W-1:0]          o_peak_frequency_hz
);

    localparam int CNT_W  = $clog2(FFT_SIZE);
    localparam int SHIFT  = $clog2(FFT_SIZE + 1) - 1;
    localparam int CMP_W  = (CNT_W > START_W) ? CNT_W : START_W;
    localparam int FPROD_W = CNT_W + SPACING_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FFT_SIZE - 1);

    logic [START_W-1:0]   r_band_first;
    logic [START_W-1:0]   r_end_bin;
    logic [SPACING_W-1:0] r_spacing;
    logic [IND_W-1:0]     r_threshold;

    logic signed [SAMPLE_W-1:0] r_re;
    logic signed [SAMPLE_W-1:0] r_im;
    logic                       r_last;
    logic [CNT_W-1:0]           r_bin_cnt;
    logic [SQUARE_W-1:0]        r_sq_re;
    logic [SQUARE_W-1:0]        r_sq_im;
    logic [FREQ_W-1:0]          r_freq;
    logic                       r_in_band;
    logic [POWER_W-1:0]         r_best_power;
    logic [FREQ_W-1:0]          r_best_freq;
    logic [IND_W-1:0]           r_ind;
    logic [POWER_W-1:0]         r_res_power;
    logic [FREQ_W-1:0]          r_res_freq;
    logic                       r_out_valid;
    logic                       r_out_slip;
    logic [IND_W-1:0]           r_out_ind;
    logic [POWER_W-1:0]         r_out_power;
    logic [FREQ_W-1:0]          r_out_freq;

    logic signed [2*SAMPLE_W-1:0] sq_re_full;
    logic signed [2*SAMPLE_W-1:0] sq_im_full;
    logic [FPROD_W-1:0]           freq_prod;
    logic [POWER_W:0]             power_sum;
    logic [POWER_W-1:0]           power;
    logic                         band_hit;

    assign sq_re_full = r_re * r_re;
    assign sq_im_full = r_im * r_im;
    assign freq_prod  = FPROD_W'(r_bin_cnt) * FPROD_W'(r_spacing);
    assign band_hit   = (CMP_W'(r_bin_cnt) >= CMP_W'(r_band_first)) &&
                        (CMP_W'(r_bin_cnt) <  CMP_W'(r_end_bin));
    assign power_sum  = (POWER_W + 1)'(r_sq_re) + (POWER_W + 1)'(r_sq_im);
    assign power      = POWER_W'(power_sum >> SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_first <= '0;
            r_end_bin    <= '0;
            r_spacing    <= '0;
            r_threshold  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BAND_FIRST:     r_band_first <= i_cfg_data[START_W-1:0];
                CFG_END_BIN:        r_end_bin    <= i_cfg_data[START_W-1:0];
                CFG_BIN_SPACING_HZ: r_spacing    <= i_cfg_data[SPACING_W-1:0];
                CFG_SLIP_THRESHOLD: r_threshold  <= i_cfg_data[IND_W-1:0];
                default: ;
            endcase
        end
    end

    // Payload registers of the item at work.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re   <= i_bin_real;
            r_im   <= i_bin_imag;
            r_last <= i_last_bin;
        end
        if (i_cmd.square) begin
            r_sq_re   <= sq_re_full[SQUARE_W-1:0];
            r_sq_im   <= sq_im_full[SQUARE_W-1:0];
            r_freq    <= FREQ_W'(freq_prod);
            r_in_band <= band_hit;
        end
        if (i_cmd.product) begin
            r_ind       <= IND_W'(r_best_power) * IND_W'(r_best_freq);
            r_res_power <= r_best_power;
            r_res_freq  <= r_best_freq;
        end
        if (i_cmd.emit) begin
            r_out_slip  <= (r_ind > r_threshold);
            r_out_ind   <= r_ind;
            r_out_power <= r_res_power;
            r_out_freq  <= r_res_freq;
        end
    end

    // Frame state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt    <= '0;
            r_best_power <= '0;
            r_best_freq  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                if (r_in_band && (power > r_best_power)) begin
                    r_best_power <= power;
                    r_best_freq  <= r_freq;
                end
                if (r_last || (r_bin_cnt == CNT_LAST)) begin
                    r_bin_cnt <= '0;
                end else begin
                    r_bin_cnt <= r_bin_cnt + 1'b1;
                end
            end
            if (i_cmd.product) begin
                r_best_power <= '0;
                r_best_freq  <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid         = r_out_valid;
    assign o_slip_detected     = r_out_slip;
    assign o_slip_metric       = r_out_ind;
    assign o_peak_power        = r_out_power;
    assign o_peak_frequency_hz = r_out_freq;

endmodule

@@ rtl/core/spectral_band_peak_slip_detector_core.sv @@
// Top level of the spectral band peak slip detector.
//
// Input channel: one FFT bin per word (i_bin_real, i_bin_imag, i_last_bin),
// in bin order, taken when i_in_valid and o_in_ready are both high.
// An internal counter numbers the bins from 0 and restarts after the word
// marked last, or wraps at FFT_SIZE. Bins from the band's first bin up to
// but not including end_bin contribute power (re*re + im*im) >> floor(log2(FFT_SIZE));
// the strictly greatest power and its frequency (index * bin_spacing_hz) are
// kept per frame.
// Output channel: one result word per frame, after the last bin, taken when
// o_out_valid and i_out_ready are both high.
// Each bin steps through accept, square and update in the controller
// sequence; no new bin is taken until its update is done. A last bin
// adds a product step and an output load step, and its result is valid
// once the load step finds the output register free.
// The output register parts the two sides: the next frame's bins are taken
// while a result waits. If the receiver stalls and a new result is ready,
// the block holds it and takes no more bins until the register frees.
// Reset clears the configuration registers, the bin counter, the peak
// state and the output valid flag. Write configuration only while idle.
module spectral_band_peak_slip_detector_core
    import sbpsd_pkg::*;
#(
    parameter int FFT_SIZE = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_bin_real,
    input  logic signed [SAMPLE_W-1:0] i_bin_imag,
    input  logic                       i_last_bin,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_slip_detected,
    output logic [IND_W-1:0]           o_slip_metric,
    output logic [POWER_W-1:0]         o_peak_power,
    output logic [FREQ_W-1:0]          o_peak_frequency_hz
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence each word through square, update and, on the last bin, product and emit.
    sbpsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Hold configuration, frame state and the output register.
    sbpsd_datapath #(
        .FFT_SIZE (FFT_SIZE)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_bin_real          (i_bin_real),
        .i_bin_imag          (i_bin_imag),
        .i_last_bin          (i_last_bin),
        .i_cmd               (dp_cmd),
        .o_stat              (dp_stat),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_slip_detected     (o_slip_detected),
        .o_slip_metric       (o_slip_metric),
        .o_peak_power        (o_peak_power),
        .o_peak_frequency_hz (o_peak_frequency_hz)
    );

endmodule
